// ----- rtl/xcfp_pkg.sv -----
// Shared types and constants for the XOR-checked frame parser.
package xcfp_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int IDX_W        = $clog2(BUFFER_BYTES + 1);
  localparam int BYTE_W       = 8;
  localparam int STATUS_W     = 2;
  localparam int PHASE_W      = 2;
  localparam int CFG_IDX_W    = 1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADSUM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOSTART  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_SEED = 1'd1;

  localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'd177;
  localparam logic [BYTE_W-1:0] CHECKSUM_SEED_RST = 8'd255;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   frame_len;
    logic [BYTE_W-1:0]   computed_checksum;
  } res_t;

endpackage

// ----- rtl/xcfp_in_if.sv -----
// Byte input channel: valid/ready handshake with one received byte.
interface xcfp_in_if import xcfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/xcfp_out_if.sv -----
// Result channel: valid/ready handshake with frame status, length and checksum.
interface xcfp_out_if import xcfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   frame_len;
  logic [BYTE_W-1:0]   computed_checksum;

  modport source (output valid, output status, output frame_len,
                  output computed_checksum, input ready);
  modport sink   (input valid, input status, input frame_len,
                  input computed_checksum, output ready);
endinterface

// ----- rtl/xcfp_parse.sv -----
// Frame parser state and per-word decode: hunt, header/data, checksum check.
module xcfp_parse import xcfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] start_byte,
  input  logic [BYTE_W-1:0] checksum_seed,
  output res_t              res
);

  localparam logic [PHASE_W-1:0] PH_HUNT  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BODY  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_CHECK = 2'd2;
  localparam int CMP_W = (IDX_W > BYTE_W) ? IDX_W : BYTE_W;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [BYTE_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0]  xor_r, xor_nxt;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    res       = '0;
    case (phase_r)
      PH_BODY: begin
        if (idx_r >= IDX_W'(BUFFER_BYTES)) begin
          res.valid             = 1'b1;
          res.status            = ST_OVERFLOW;
          res.frame_len         = len_r;
          res.computed_checksum = xor_r;
          phase_nxt             = PH_HUNT;
        end else begin
          if (idx_r == IDX_W'(1)) begin
            len_nxt = rx_byte;
          end else begin
            xor_nxt = xor_r ^ rx_byte;
          end
          if (CMP_W'(idx_r) == CMP_W'(len_nxt)) begin
            phase_nxt = PH_CHECK;
          end
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      PH_CHECK: begin
        res.valid             = 1'b1;
        res.status            = (rx_byte == xor_r) ? ST_OK : ST_BADSUM;
        res.frame_len         = len_r;
        res.computed_checksum = xor_r;
        phase_nxt             = PH_HUNT;
      end
      default: begin
        if (rx_byte == start_byte) begin
          xor_nxt   = checksum_seed;
          idx_nxt   = IDX_W'(1);
          phase_nxt = PH_BODY;
        end else begin
          res.valid  = 1'b1;
          res.status = ST_NOSTART;
          phase_nxt  = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= '0;
      len_r   <= '0;
      xor_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
    end
  end

  a_phase_known: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HUNT || phase_r == PH_BODY || phase_r == PH_CHECK)
    else $error("parser phase left the valid codes");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(BUFFER_BYTES))
    else $error("byte index beyond buffer size");

  a_body_result: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY && res.valid |-> res.status == ST_OVERFLOW)
    else $error("body word produced a result other than overflow");

endmodule

// ----- rtl/xcfp_out_reg.sv -----
// Result register with valid/ready toward the result channel.
module xcfp_out_reg import xcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  output logic       slot_free,
  xcfp_out_if.source out_ch
);

  logic                valid_r, valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [BYTE_W-1:0]   len_r;
  logic [BYTE_W-1:0]   sum_r;

  assign slot_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (load && res.valid) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      status_r <= res.status;
      len_r    <= res.frame_len;
      sum_r    <= res.computed_checksum;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.status            = status_r;
  assign out_ch.frame_len         = len_r;
  assign out_ch.computed_checksum = sum_r;

endmodule

// ----- rtl/xor_checked_frame_parser_unit.sv -----
// Top level of the XOR-checked frame parser: input stage, config, parser, result stage.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+-----------------------------------------
//   in_ch    | in  | valid/ready           | rx_byte[7:0]
//   out_ch   | out | valid/ready           | status[1:0], frame_len, computed_checksum
//   cfg_*    | in  | cfg_we, no back-press | cfg_index[0], cfg_data[7:0]
//
// One word per cycle sustained while out_ch is not stalled; an accepted word passes
// through the input register, then parser decode into the result register.
// Synchronous active-low reset empties both stages, sets the parser to hunting
// and loads start byte 177 and checksum seed 255.
// A stalled result blocks the input register only once it holds a word that
// cannot advance; in_ch.ready stays high otherwise.
module xor_checked_frame_parser_unit import xcfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  xcfp_in_if.sink              in_ch,
  xcfp_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  logic              in_v_r, in_v_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic [BYTE_W-1:0] start_byte_r;
  logic [BYTE_W-1:0] checksum_seed_r;
  logic              slot_free;
  logic              advance;
  res_t              res;

  assign advance     = in_v_r && slot_free;
  assign in_ch.ready = !in_v_r || slot_free;

  always_comb begin
    in_v_nxt = in_v_r;
    if (advance) begin
      in_v_nxt = 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r    <= START_BYTE_RST;
      checksum_seed_r <= CHECKSUM_SEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE:    start_byte_r    <= cfg_data;
        CFG_CHECKSUM_SEED: checksum_seed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  xcfp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .rx_byte       (in_byte_r),
    .start_byte    (start_byte_r),
    .checksum_seed (checksum_seed_r),
    .res           (res)
  );

  xcfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while both stages are full");

  a_nostart_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_NOSTART
      |-> out_ch.frame_len == '0 && out_ch.computed_checksum == '0)
    else $error("not-start result carries nonzero fields");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.valid |=> out_ch.valid)
    else $error("result lost on its way to the output register");

endmodule
